// File: rtl/sha1sh_pkg.sv
// Package for the SHA-1 stream hash: types, constants and helper functions.
// No dependencies; the sequencer, schedule, round unit and top level import it.
package sha1sh_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_BITS   = 512;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned NUM_ROUNDS   = 80;

  localparam logic [6:0] RND_P1_START  = 7'd20;
  localparam logic [6:0] RND_MAJ_START = 7'd40;
  localparam logic [6:0] RND_P2_START  = 7'd60;
  localparam logic [6:0] RND_LAST      = 7'(NUM_ROUNDS - 1);
  localparam logic [2:0] LAST_WORD     = 3'(DIGEST_WORDS - 1);

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  // Initial chaining value, element 0 is the most significant digest word.
  localparam logic [DIGEST_WORDS-1:0][WORD_W-1:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [WORD_W-1:0] K_CH   = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_PAR2 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_ph_t;

  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR1,
    FN_MAJ,
    FN_PAR2
  } rfn_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic       push;       // shift one byte into the block line
    logic [7:0] byte_val;
    logic       rnd_en;     // run one compression round
    rfn_t       fn;
    logic       load_work;  // working vars <= chain words
    logic       fold;       // one step of the chain add-back
    logic       h_shift;    // rotate chain words toward the output
    logic       h_init;     // reload the initial chaining value
  } dp_ctl_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    rotl32 = (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input rfn_t fn);
    case (fn)
      FN_CH:   round_k = K_CH;
      FN_PAR1: round_k = K_PAR1;
      FN_MAJ:  round_k = K_MAJ;
      FN_PAR2: round_k = K_PAR2;
      default: round_k = K_CH;
    endcase
  endfunction

endpackage

// File: rtl/sha1sh_if.sv
// Valid/ready channel interfaces for the SHA-1 stream hash.
// Depends on nothing; used by the top level.
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink   (input valid, digest_word, word_number, final_word, output ready);
endinterface

// File: rtl/sha1sh_sched.sv
// Block line and message schedule: 64 bytes shift in, then 80 schedule words shift out.
// Depends on sha1sh_pkg.
module sha1sh_sched
  import sha1sh_pkg::*;
(
  input  logic              clk,
  input  dp_ctl_t           ctl,
  output logic [WORD_W-1:0] w_cur
);

  // Word 0 (oldest) sits in the top 32 bits.
  logic [BLOCK_BITS-1:0] line_r, line_nxt;
  logic [WORD_W-1:0]     w_new;

  function automatic logic [WORD_W-1:0] word_at(input logic [BLOCK_BITS-1:0] v,
                                                input int unsigned k);
    word_at = v[BLOCK_BITS - 1 - WORD_W * k -: WORD_W];
  endfunction

  assign w_cur = word_at(line_r, 0);
  assign w_new = rotl32(word_at(line_r, 13) ^ word_at(line_r, 8) ^
                        word_at(line_r, 2) ^ word_at(line_r, 0), 1);

  always_comb begin
    line_nxt = line_r;
    if (ctl.push) begin
      line_nxt = {line_r[BLOCK_BITS-9:0], ctl.byte_val};
    end else if (ctl.rnd_en) begin
      line_nxt = {line_r[BLOCK_BITS-WORD_W-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

endmodule

// File: rtl/sha1sh_round.sv
// Shared round unit: working variables, the round adder and the chain words.
// Depends on sha1sh_pkg.
module sha1sh_round
  import sha1sh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  input  logic [WORD_W-1:0] w_cur,
  output logic [WORD_W-1:0] digest_word
);

  logic [WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [DIGEST_WORDS-1:0][WORD_W-1:0] h_r, h_nxt;
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] t_val;

  always_comb begin
    case (ctl.fn)
      FN_CH:   f_val = (b_r & c_r) | (~b_r & d_r);
      FN_MAJ:  f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f_val = b_r ^ c_r ^ d_r;
    endcase
  end

  assign t_val = rotl32(a_r, 5) + f_val + e_r + round_k(ctl.fn) + w_cur;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    h_nxt = h_r;
    if (ctl.load_work) begin
      a_nxt = h_r[0];
      b_nxt = h_r[1];
      c_nxt = h_r[2];
      d_nxt = h_r[3];
      e_nxt = h_r[4];
    end else if (ctl.rnd_en) begin
      a_nxt = t_val;
      b_nxt = a_r;
      c_nxt = rotl32(b_r, 30);
      d_nxt = c_r;
      e_nxt = d_r;
    end else if (ctl.fold) begin
      // five steps of rotate-and-add leave h[i] = h[i] + work[i]
      a_nxt = b_r;
      b_nxt = c_r;
      c_nxt = d_r;
      d_nxt = e_r;
      e_nxt = a_r;
      h_nxt = {h_r[0] + a_r, h_r[4:1]};
    end
    if (ctl.h_init) begin
      h_nxt = H_INIT;
    end else if (ctl.h_shift) begin
      h_nxt = {h_r[0], h_r[4:1]};
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
    if (!rst_n) begin
      h_r <= H_INIT;
    end else begin
      h_r <= h_nxt;
    end
  end

  assign digest_word = h_r[0];

endmodule

// File: rtl/sha1sh_ctrl.sv
// Sequencer: byte intake, padding, round count, chain fold and digest output.
// Depends on sha1sh_pkg.
module sha1sh_ctrl
  import sha1sh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] msg_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] word_number,
  output logic       final_word,
  output dp_ctl_t    ctl
);

  state_t      state_r, state_nxt;
  pad_ph_t     ph_r, ph_nxt;
  logic        pad_r, pad_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        in_acc;
  logic        out_acc;
  logic        len_sel;
  logic [63:0] len_sh;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign len_sel = (ph_r == PH_LEN) || (ph_r == PH_ZERO && fill_r == LEN_POS);
  assign len_sh  = bits_r << {fill_r[2:0], 3'b000};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && has_byte && fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end else if (in_acc && end_of_message) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cnt_r == LAST_WORD) begin
          if (!pad_r) begin
            state_nxt = ST_IDLE;
          end else if (ph_r == PH_LEN) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (out_acc && cnt_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctl         = '0;
    ctl.fn      = FN_CH;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ph_nxt      = ph_r;
    pad_nxt     = pad_r;
    fill_nxt    = fill_r;
    bits_nxt    = bits_r;
    rnd_nxt     = rnd_r;
    cnt_nxt     = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (has_byte) begin
            ctl.push     = 1'b1;
            ctl.byte_val = msg_byte;
            bits_nxt     = bits_r + 64'd8;
            fill_nxt     = fill_r + 6'd1;
            ctl.load_work = (fill_r == FILL_LAST);
          end
          if (end_of_message) begin
            pad_nxt = 1'b1;
            ph_nxt  = PH_MARK;
          end
        end
        rnd_nxt = '0;
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        if (ph_r == PH_MARK) begin
          ctl.byte_val = PAD_MARK;
          ph_nxt       = PH_ZERO;
        end else if (len_sel) begin
          ctl.byte_val = len_sh[63:56];
          ph_nxt       = PH_LEN;
        end else begin
          ctl.byte_val = 8'h00;
        end
        fill_nxt      = fill_r + 6'd1;
        ctl.load_work = (fill_r == FILL_LAST);
        rnd_nxt       = '0;
      end
      ST_ROUND: begin
        ctl.rnd_en = 1'b1;
        if (rnd_r < RND_P1_START) begin
          ctl.fn = FN_CH;
        end else if (rnd_r < RND_MAJ_START) begin
          ctl.fn = FN_PAR1;
        end else if (rnd_r < RND_P2_START) begin
          ctl.fn = FN_MAJ;
        end else begin
          ctl.fn = FN_PAR2;
        end
        rnd_nxt = rnd_r + 7'd1;
        cnt_nxt = '0;
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        cnt_nxt  = (cnt_r == LAST_WORD) ? 3'd0 : cnt_r + 3'd1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_acc) begin
          ctl.h_shift = 1'b1;
          cnt_nxt     = cnt_r + 3'd1;
          if (cnt_r == LAST_WORD) begin
            ctl.h_init = 1'b1;
            cnt_nxt    = '0;
            bits_nxt   = '0;
            pad_nxt    = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign word_number = cnt_r;
  assign final_word  = (cnt_r == LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_MARK;
      pad_r   <= 1'b0;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      pad_r   <= pad_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      rnd_r   <= rnd_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/sha1_stream_hash.sv
// SHA-1 stream hash, top level: sequencer, block line/schedule and round unit.
// Depends on sha1sh_pkg, sha1sh_if, sha1sh_ctrl, sha1sh_sched, sha1sh_round.
//
// Computes the 160-bit SHA-1 digest of a byte stream. Each input transaction
// carries at most one message byte (has_byte) and may mark the end of the
// message (end_of_message); a transaction with neither changes nothing, and
// an end marker with no byte is legal, so an empty message can be hashed.
// Timing: a data byte is taken in any cycle in which in_ch.ready is high.
// The transaction that completes a 64-byte block is followed by a busy
// period (80 rounds, one per cycle through the single round adder, then
// five steps folding the working words back into the chain words);
// in_ch.ready is low meanwhile. On the end transaction the padding bytes
// (0x80, zeros, 64-bit bit length), 9 to 72 bytes, are shifted in one per
// cycle apart from one or two compressions, and then the five digest words
// are offered on out_ch, word 0 (most significant) first, final_word set
// on word 4. Input is not taken until the last word has been taken; then
// the engine is back at its initial chaining value and zero length. The
// length counter wraps modulo 2^64. No clearing pass is needed at reset.
module sha1_stream_hash
  import sha1sh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sha1sh_in_if.sink    in_ch,
  sha1sh_out_if.source out_ch
);

  dp_ctl_t           ctl;
  logic [WORD_W-1:0] w_cur;
  logic [WORD_W-1:0] digest_word;

  sha1sh_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .msg_byte       (in_ch.msg_byte),
    .has_byte       (in_ch.has_byte),
    .end_of_message (in_ch.end_of_message),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .word_number    (out_ch.word_number),
    .final_word     (out_ch.final_word),
    .ctl            (ctl)
  );

  // message block and 80-word schedule
  sha1sh_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  // shared round adder and chaining words; word 0 of the chain drives the output
  sha1sh_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .w_cur       (w_cur),
    .digest_word (digest_word)
  );

  assign out_ch.digest_word = digest_word;

endmodule

// File: rtl/sha1sh_checker.sv
// Port-level checks for the SHA-1 stream hash, bound to the top level.
// Depends on sha1_stream_hash.
module sha1sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        has_byte,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_number,
  input logic        final_word
);

  // input is never taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digest pending");

  // final flag marks word 4 exactly
  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (final_word == (word_number == 3'd4)))
    else $error("final_word does not match word_number");

  // words come out in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !final_word) |=>
      (out_valid && word_number == 3'($past(word_number) + 3'd1)))
    else $error("digest words out of order");

  // after the last word, the engine goes back to taking input
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && final_word) |=> (!out_valid && in_ready))
    else $error("not idle after final digest word");

  // an empty transaction leaves the engine ready
  a_idle_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !has_byte && !end_of_message) |=> in_ready)
    else $error("empty transaction made the engine busy");

endmodule

bind sha1_stream_hash sha1sh_checker u_sha1sh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .has_byte       (in_ch.has_byte),
  .end_of_message (in_ch.end_of_message),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .word_number    (out_ch.word_number),
  .final_word     (out_ch.final_word)
);
